### rtl/necir_pkg.sv
// Shared types, codes and constants of the NEC infrared frame decoder.
package necir_pkg;

  localparam int unsigned DurW = 14;
  localparam int unsigned LimW = 12;
  localparam int unsigned ByteW = 8;
  localparam int unsigned StatusW = 4;
  localparam int unsigned IdxW = 3;
  localparam logic [DurW-1:0] DurMax = '1;
  localparam int unsigned FifoDepth = 3;
  localparam int unsigned FifoPtrW = 2;
  localparam int unsigned FifoCntW = 2;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LEAD_LOW,
    PH_LEAD_HIGH,
    PH_ADDR_LOW,
    PH_ADDR_HIGH,
    PH_ADDR_INV_LOW,
    PH_ADDR_INV_HIGH,
    PH_CMD_LOW,
    PH_CMD_HIGH,
    PH_CMD_INV_LOW,
    PH_CMD_INV_HIGH
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK,
    ST_LEAD_LOW_LONG,
    ST_LEAD_LOW_SHORT,
    ST_LEAD_HIGH_LONG,
    ST_LEAD_HIGH_SHORT,
    ST_ADDR_TIMEOUT,
    ST_ADDR_INV_LOW_SHORT,
    ST_ADDR_INV_HIGH_LONG,
    ST_ADDR_INV_HIGH_SHORT,
    ST_CMD_TIMEOUT,
    ST_CMD_INV_LOW_SHORT,
    ST_CMD_INV_HIGH_LONG,
    ST_CMD_INV_HIGH_SHORT
  } status_e;

  typedef enum logic [IdxW-1:0] {
    REG_LEAD_LOW_MIN,
    REG_LEAD_LOW_MAX,
    REG_LEAD_HIGH_MIN,
    REG_LEAD_HIGH_MAX,
    REG_BIT_LIMIT,
    REG_ADDR_INV_LOW_MIN,
    REG_CMD_INV_LOW_MIN
  } reg_idx_e;

  typedef struct packed {
    logic [DurW-1:0] lead_low_min;
    logic [DurW-1:0] lead_low_max;
    logic [DurW-1:0] lead_high_min;
    logic [DurW-1:0] lead_high_max;
    logic [LimW-1:0] bit_limit;
    logic [LimW-1:0] addr_inv_low_min;
    logic [LimW-1:0] cmd_inv_low_min;
  } cfg_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   address;
    logic [ByteW-1:0]   command;
  } result_t;

endpackage

### rtl/necir_core.sv
// Frame decoding state machine: one pin sample per step, at most one status result.
module necir_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   pin_i,
  input  logic                   release_i,
  input  necir_pkg::cfg_t        cfg_i,
  output logic                   res_valid_o,
  output necir_pkg::result_t     res_o
);

  necir_pkg::phase_e                  phase_q, phase_d;
  logic [necir_pkg::DurW-1:0]         dur_q, dur_d;
  logic [2:0]                         bidx_q, bidx_d;
  logic [necir_pkg::ByteW-1:0]        haddr_q, haddr_d;
  logic [necir_pkg::ByteW-1:0]        hcmd_q, hcmd_d;
  logic                               last_pin_q;

  logic                               emit;
  necir_pkg::status_e                 code;
  logic [necir_pkg::DurW-1:0]         bumped;
  logic [necir_pkg::DurW-1:0]         limit_ext;
  logic [necir_pkg::DurW-1:0]         inv_min_ext;
  logic [3:0]                         offset;
  logic [1:0]                         grp;
  logic [1:0]                         next_grp;
  logic                               inv;
  logic [necir_pkg::ByteW-1:0]        cur_byte;
  logic                               dbit;
  logic                               lim_zero;
  logic [necir_pkg::ByteW-1:0]        mask;

  assign bumped      = (dur_q == necir_pkg::DurMax) ? dur_q : dur_q + 1'b1;
  assign limit_ext   = {2'b00, cfg_i.bit_limit};
  assign lim_zero    = (cfg_i.bit_limit == '0);
  assign offset      = 4'(phase_q) - 4'(necir_pkg::PH_ADDR_LOW);
  assign grp         = offset[2:1];
  assign next_grp    = grp + 2'd1;
  assign inv         = grp[0];
  assign inv_min_ext = grp[1] ? {2'b00, cfg_i.cmd_inv_low_min}
                              : {2'b00, cfg_i.addr_inv_low_min};
  assign mask        = 8'h80 >> bidx_q;

  always_comb begin
    phase_d  = phase_q;
    dur_d    = dur_q;
    bidx_d   = bidx_q;
    haddr_d  = release_i ? '0 : haddr_q;
    hcmd_d   = release_i ? '0 : hcmd_q;
    emit     = 1'b0;
    code     = necir_pkg::ST_OK;
    cur_byte = grp[1] ? hcmd_d : haddr_d;
    dbit     = |(cur_byte & mask);
    case (phase_q)
      necir_pkg::PH_IDLE: begin
        if (last_pin_q && !pin_i && !((haddr_d != '0) && (hcmd_d != '0))) begin
          phase_d = necir_pkg::PH_LEAD_LOW;
          dur_d   = 14'd1;
          if (cfg_i.lead_low_max == '0) begin
            emit = 1'b1;
            code = necir_pkg::ST_LEAD_LOW_LONG;
          end
        end
      end
      necir_pkg::PH_LEAD_LOW: begin
        if (!pin_i) begin
          dur_d = bumped;
          if (bumped > cfg_i.lead_low_max) begin
            emit = 1'b1;
            code = necir_pkg::ST_LEAD_LOW_LONG;
          end
        end else if (dur_q < cfg_i.lead_low_min) begin
          emit = 1'b1;
          code = necir_pkg::ST_LEAD_LOW_SHORT;
        end else begin
          phase_d = necir_pkg::PH_LEAD_HIGH;
          dur_d   = 14'd1;
          if (cfg_i.lead_high_max == '0) begin
            emit = 1'b1;
            code = necir_pkg::ST_LEAD_HIGH_LONG;
          end
        end
      end
      necir_pkg::PH_LEAD_HIGH: begin
        if (pin_i) begin
          dur_d = bumped;
          if (bumped > cfg_i.lead_high_max) begin
            emit = 1'b1;
            code = necir_pkg::ST_LEAD_HIGH_LONG;
          end
        end else if (dur_q < cfg_i.lead_high_min) begin
          emit = 1'b1;
          code = necir_pkg::ST_LEAD_HIGH_SHORT;
        end else begin
          haddr_d = '0;
          bidx_d  = '0;
          phase_d = necir_pkg::PH_ADDR_LOW;
          dur_d   = 14'd1;
          if (lim_zero) begin
            emit = 1'b1;
            code = necir_pkg::ST_ADDR_TIMEOUT;
          end
        end
      end
      necir_pkg::PH_ADDR_LOW, necir_pkg::PH_ADDR_INV_LOW,
      necir_pkg::PH_CMD_LOW, necir_pkg::PH_CMD_INV_LOW: begin
        if (!pin_i) begin
          dur_d = bumped;
          if (bumped > limit_ext) begin
            emit = 1'b1;
            code = grp[1] ? necir_pkg::ST_CMD_TIMEOUT : necir_pkg::ST_ADDR_TIMEOUT;
          end
        end else if (inv && (dur_q < inv_min_ext)) begin
          emit = 1'b1;
          code = grp[1] ? necir_pkg::ST_CMD_INV_LOW_SHORT
                        : necir_pkg::ST_ADDR_INV_LOW_SHORT;
        end else begin
          phase_d = necir_pkg::phase_e'(4'(phase_q) + 4'd1);
          dur_d   = 14'd1;
          if (inv && lim_zero && dbit) begin
            emit = 1'b1;
            code = grp[1] ? necir_pkg::ST_CMD_INV_HIGH_LONG
                          : necir_pkg::ST_ADDR_INV_HIGH_LONG;
          end
        end
      end
      necir_pkg::PH_ADDR_HIGH, necir_pkg::PH_ADDR_INV_HIGH,
      necir_pkg::PH_CMD_HIGH, necir_pkg::PH_CMD_INV_HIGH: begin
        if (pin_i) begin
          dur_d = bumped;
          if (inv && (bumped > limit_ext) && dbit) begin
            emit = 1'b1;
            code = grp[1] ? necir_pkg::ST_CMD_INV_HIGH_LONG
                          : necir_pkg::ST_ADDR_INV_HIGH_LONG;
          end
        end else if (inv && (dur_q < limit_ext) && !dbit) begin
          emit = 1'b1;
          code = grp[1] ? necir_pkg::ST_CMD_INV_HIGH_SHORT
                        : necir_pkg::ST_ADDR_INV_HIGH_SHORT;
        end else begin
          if (!inv && (dur_q > limit_ext)) begin
            if (grp[1]) begin
              hcmd_d = hcmd_d | mask;
            end else begin
              haddr_d = haddr_d | mask;
            end
          end
          if (bidx_q != 3'd7) begin
            bidx_d  = bidx_q + 3'd1;
            phase_d = necir_pkg::phase_e'(4'(necir_pkg::PH_ADDR_LOW) + {1'b0, grp, 1'b0});
            dur_d   = 14'd1;
            if (lim_zero) begin
              emit = 1'b1;
              code = grp[1] ? necir_pkg::ST_CMD_TIMEOUT : necir_pkg::ST_ADDR_TIMEOUT;
            end
          end else begin
            bidx_d = '0;
            if (grp == 2'd3) begin
              emit = 1'b1;
              code = necir_pkg::ST_OK;
            end else begin
              if (grp == 2'd1) begin
                hcmd_d = '0;
              end
              phase_d = necir_pkg::phase_e'(4'(necir_pkg::PH_ADDR_LOW)
                                            + {1'b0, next_grp, 1'b0});
              dur_d   = 14'd1;
              if (lim_zero) begin
                emit = 1'b1;
                code = next_grp[1] ? necir_pkg::ST_CMD_TIMEOUT
                                   : necir_pkg::ST_ADDR_TIMEOUT;
              end
            end
          end
        end
      end
      default: begin
        phase_d = necir_pkg::PH_IDLE;
      end
    endcase
    if (emit) begin
      phase_d = necir_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= necir_pkg::PH_IDLE;
      dur_q      <= '0;
      bidx_q     <= '0;
      haddr_q    <= '0;
      hcmd_q     <= '0;
      last_pin_q <= 1'b1;
    end else if (step_i) begin
      phase_q    <= phase_d;
      dur_q      <= dur_d;
      bidx_q     <= bidx_d;
      haddr_q    <= haddr_d;
      hcmd_q     <= hcmd_d;
      last_pin_q <= pin_i;
    end
  end

  assign res_valid_o   = step_i && emit;
  assign res_o.status  = code;
  assign res_o.address = haddr_d;
  assign res_o.command = hcmd_d;

endmodule

### rtl/necir_out_fifo.sv
// Small result queue that decouples the decoder from a stalling receiver.
module necir_out_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  necir_pkg::result_t                data_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output necir_pkg::result_t                data_o,
  output logic [necir_pkg::FifoCntW-1:0]    count_o
);

  necir_pkg::result_t                 mem_q [necir_pkg::FifoDepth];
  logic [necir_pkg::FifoPtrW-1:0]     wr_q, rd_q;
  logic [necir_pkg::FifoCntW-1:0]     cnt_q;
  logic                               do_pop;

  localparam logic [necir_pkg::FifoPtrW-1:0] LastPtr =
    necir_pkg::FifoPtrW'(necir_pkg::FifoDepth - 1);

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

### rtl/nec_ir_frame_decoder.sv
// Top level of the NEC infrared frame decoder with its configuration registers.
// The decoder takes one pin sample per cycle unless stalled; each is decoded in a
// single pass of the frame state machine behind a one-stage input register. The
// status result of the sample that ends or fails a frame then waits in a
// three-entry queue; the input stalls only when that queue and the sample in flight
// could fill it because the receiver is stalling.
// Configuration writes are always ready and take effect at once.
module nec_ir_frame_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                pin_level_i,
  input  logic                                release_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [necir_pkg::StatusW-1:0]       status_o,
  output logic [necir_pkg::ByteW-1:0]         address_o,
  output logic [necir_pkg::ByteW-1:0]         command_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [necir_pkg::IdxW-1:0]          cfg_index_i,
  input  logic [necir_pkg::DurW-1:0]          cfg_data_i
);

  necir_pkg::cfg_t                    cfg_q;
  logic                               s1_valid_q;
  logic                               s1_pin_q;
  logic                               s1_rel_q;
  logic                               in_accept;
  logic                               res_valid;
  necir_pkg::result_t                 res;
  necir_pkg::result_t                 head;
  logic [necir_pkg::FifoCntW-1:0]     fifo_cnt;
  logic [necir_pkg::FifoCntW:0]       pending;

  assign cfg_ready_o = 1'b1;
  assign pending     = {1'b0, fifo_cnt} + {{necir_pkg::FifoCntW{1'b0}}, s1_valid_q};
  assign in_stall_o  = (pending >= (necir_pkg::FifoCntW + 1)'(necir_pkg::FifoDepth));
  assign in_accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lead_low_min     <= 14'd6000;
      cfg_q.lead_low_max     <= 14'd12000;
      cfg_q.lead_high_min    <= 14'd4000;
      cfg_q.lead_high_max    <= 14'd8000;
      cfg_q.bit_limit        <= 12'd600;
      cfg_q.addr_inv_low_min <= 12'd45;
      cfg_q.cmd_inv_low_min  <= 12'd400;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        necir_pkg::REG_LEAD_LOW_MIN:     cfg_q.lead_low_min     <= cfg_data_i;
        necir_pkg::REG_LEAD_LOW_MAX:     cfg_q.lead_low_max     <= cfg_data_i;
        necir_pkg::REG_LEAD_HIGH_MIN:    cfg_q.lead_high_min    <= cfg_data_i;
        necir_pkg::REG_LEAD_HIGH_MAX:    cfg_q.lead_high_max    <= cfg_data_i;
        necir_pkg::REG_BIT_LIMIT:        cfg_q.bit_limit        <= cfg_data_i[11:0];
        necir_pkg::REG_ADDR_INV_LOW_MIN: cfg_q.addr_inv_low_min <= cfg_data_i[11:0];
        necir_pkg::REG_CMD_INV_LOW_MIN:  cfg_q.cmd_inv_low_min  <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pin_q <= pin_level_i;
      s1_rel_q <= release_req_i;
    end
  end

  necir_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_valid_q),
    .pin_i       (s1_pin_q),
    .release_i   (s1_rel_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  necir_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (head),
    .count_o (fifo_cnt)
  );

  assign status_o  = head.status;
  assign address_o = head.address;
  assign command_o = head.command;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (fifo_cnt == 2'd3)) |-> !out_stall_i)
    else $error("Result queue overflow.");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> !s1_valid_q)
    else $error("A sample entered the input register while stalled.");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res.status <= 4'd12))
    else $error("Status code out of range.");

  a_valid_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o == (fifo_cnt != '0))
    else $error("Output valid disagrees with queue fill.");
`endif

endmodule

### bench/nec_ir_frame_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench of the NEC infrared frame decoder: pin sample traffic checked against a decode model.
module nec_ir_frame_decoder_tb;
  import necir_pkg::*;

  typedef struct packed {
    logic pin;
    logic rel;
  } sample_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               pin = 1'b1;
  logic               rel = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   address;
  logic [ByteW-1:0]   command;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IdxW-1:0]    cfg_index = '0;
  logic [DurW-1:0]    cfg_data = '0;

  sample_t     pin_samples_q[$];
  result_t     frame_reports_q[$];
  sample_t     next_sample;
  result_t     want;
  int unsigned samples_queued = 0;
  int unsigned reports_predicted = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  cfg_t            timing;
  phase_e          dec_phase;
  logic [DurW-1:0] dec_count;
  logic [IdxW-1:0] dec_bit;
  logic [ByteW-1:0] dec_addr;
  logic [ByteW-1:0] dec_cmd;
  logic            dec_last_pin;
  bit              dec_emit;
  status_e         dec_status;

  nec_ir_frame_decoder i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pin_level_i  (pin),
    .release_req_i(rel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .address_o    (address),
    .command_o    (command),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void init_model();
    timing.lead_low_min = 14'd6000;
    timing.lead_low_max = 14'd12000;
    timing.lead_high_min = 14'd4000;
    timing.lead_high_max = 14'd8000;
    timing.bit_limit = 12'd600;
    timing.addr_inv_low_min = 12'd45;
    timing.cmd_inv_low_min = 12'd400;
    dec_phase = PH_IDLE;
    dec_count = '0;
    dec_bit = '0;
    dec_addr = '0;
    dec_cmd = '0;
    dec_last_pin = 1'b1;
  endfunction

  function automatic void finish_frame(status_e code);
    dec_phase = PH_IDLE;
    dec_emit = 1'b1;
    dec_status = code;
  endfunction

  function automatic void count_up();
    if (dec_count != DurMax) begin
      dec_count++;
    end
  endfunction

  function automatic logic sent_bit(int g);
    logic [ByteW-1:0] data;
    data = (g < 2) ? dec_addr : dec_cmd;
    return data[7 - dec_bit];
  endfunction

  function automatic void begin_low(int g);
    dec_phase = phase_e'(int'(PH_ADDR_LOW) + 2 * g);
    dec_count = 1;
    if (dec_count > timing.bit_limit) begin
      finish_frame(g < 2 ? ST_ADDR_TIMEOUT : ST_CMD_TIMEOUT);
    end
  endfunction

  function automatic void decode_sample(logic level, logic clear);
    int              off;
    int              g;
    bit              inv;
    bit              done;
    status_e         tmo;
    status_e         low_short;
    status_e         high_long;
    status_e         high_short;
    logic [LimW-1:0] inv_min;
    logic [LimW-1:0] bl;
    dec_emit = 1'b0;
    bl = timing.bit_limit;
    if (clear) begin
      dec_addr = '0;
      dec_cmd = '0;
    end
    case (dec_phase)
      PH_IDLE: begin
        if (dec_last_pin && !level && !(dec_addr != 0 && dec_cmd != 0)) begin
          dec_phase = PH_LEAD_LOW;
          dec_count = 1;
          if (dec_count > timing.lead_low_max) finish_frame(ST_LEAD_LOW_LONG);
        end
      end
      PH_LEAD_LOW: begin
        if (!level) begin
          count_up();
          if (dec_count > timing.lead_low_max) finish_frame(ST_LEAD_LOW_LONG);
        end else if (dec_count < timing.lead_low_min) begin
          finish_frame(ST_LEAD_LOW_SHORT);
        end else begin
          dec_phase = PH_LEAD_HIGH;
          dec_count = 1;
          if (dec_count > timing.lead_high_max) finish_frame(ST_LEAD_HIGH_LONG);
        end
      end
      PH_LEAD_HIGH: begin
        if (level) begin
          count_up();
          if (dec_count > timing.lead_high_max) finish_frame(ST_LEAD_HIGH_LONG);
        end else if (dec_count < timing.lead_high_min) begin
          finish_frame(ST_LEAD_HIGH_SHORT);
        end else begin
          dec_addr = '0;
          dec_bit = '0;
          begin_low(0);
        end
      end
      default: begin
        off = int'(dec_phase) - int'(PH_ADDR_LOW);
        g = off / 2;
        inv = (g % 2) == 1;
        tmo = (g < 2) ? ST_ADDR_TIMEOUT : ST_CMD_TIMEOUT;
        low_short = (g < 2) ? ST_ADDR_INV_LOW_SHORT : ST_CMD_INV_LOW_SHORT;
        high_long = (g < 2) ? ST_ADDR_INV_HIGH_LONG : ST_CMD_INV_HIGH_LONG;
        high_short = (g < 2) ? ST_ADDR_INV_HIGH_SHORT : ST_CMD_INV_HIGH_SHORT;
        inv_min = (g == 1) ? timing.addr_inv_low_min : timing.cmd_inv_low_min;
        done = 1'b0;
        if (off % 2 == 0) begin
          if (!level) begin
            count_up();
            if (dec_count > bl) finish_frame(tmo);
          end else if (inv && dec_count < inv_min) begin
            finish_frame(low_short);
          end else begin
            dec_phase = phase_e'(int'(dec_phase) + 1);
            dec_count = 1;
            if (inv && dec_count > bl && sent_bit(g)) finish_frame(high_long);
          end
        end else if (level) begin
          count_up();
          if (inv && dec_count > bl && sent_bit(g)) finish_frame(high_long);
        end else begin
          if (!inv) begin
            if (dec_count > bl) begin
              if (g == 0) dec_addr[7 - dec_bit] = 1'b1;
              else dec_cmd[7 - dec_bit] = 1'b1;
            end
          end else if (dec_count < bl && !sent_bit(g)) begin
            finish_frame(high_short);
            done = 1'b1;
          end
          if (!done) begin
            if (dec_bit != 3'd7) begin
              dec_bit++;
              begin_low(g);
            end else begin
              dec_bit = '0;
              if (g == 3) begin
                finish_frame(ST_OK);
              end else begin
                if (g == 1) dec_cmd = '0;
                begin_low(g + 1);
              end
            end
          end
        end
      end
    endcase
    dec_last_pin = level;
    if (dec_emit) begin
      frame_reports_q.push_back(result_t'{status: dec_status, address: dec_addr,
                                          command: dec_cmd});
      reports_predicted++;
    end
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_sample(pin, rel);
      end
      if (!in_valid || !in_stall) begin
        if (pin_samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sample = pin_samples_q.pop_front();
          in_valid <= 1'b1;
          pin <= next_sample.pin;
          rel <= next_sample.rel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_reports_q.size() == 0) begin
          $display("%0t: unexpected report status %0d address %0d command %0d",
                   $time, status, address, command);
          mismatches++;
        end else begin
          want = frame_reports_q.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
          end
          if (address !== want.address) begin
            $display("%0t: address expected %0d actual %0d", $time, want.address, address);
            mismatches++;
          end
          if (command !== want.command) begin
            $display("%0t: command expected %0d actual %0d", $time, want.command, command);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [DurW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LEAD_LOW_MIN: timing.lead_low_min = value;
      REG_LEAD_LOW_MAX: timing.lead_low_max = value;
      REG_LEAD_HIGH_MIN: timing.lead_high_min = value;
      REG_LEAD_HIGH_MAX: timing.lead_high_max = value;
      REG_BIT_LIMIT: timing.bit_limit = value[LimW-1:0];
      REG_ADDR_INV_LOW_MIN: timing.addr_inv_low_min = value[LimW-1:0];
      REG_CMD_INV_LOW_MIN: timing.cmd_inv_low_min = value[LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [DurW-1:0] ll_min, ll_max, lh_min, lh_max, bl,
                            a_min, c_min);
    write_reg(REG_LEAD_LOW_MIN, ll_min);
    write_reg(REG_LEAD_LOW_MAX, ll_max);
    write_reg(REG_LEAD_HIGH_MIN, lh_min);
    write_reg(REG_LEAD_HIGH_MAX, lh_max);
    write_reg(REG_BIT_LIMIT, bl);
    write_reg(REG_ADDR_INV_LOW_MIN, a_min);
    write_reg(REG_CMD_INV_LOW_MIN, c_min);
  endtask

  task automatic pick_timing();
    int unsigned bl;
    int unsigned ll_min;
    int unsigned lh_min;
    if ($urandom_range(3) == 0) begin
      set_timing(14'($urandom_range(3)), 14'($urandom_range(3)), 14'($urandom_range(3)),
                 14'($urandom_range(3)), 14'($urandom_range(3)), 14'($urandom_range(3)),
                 14'($urandom_range(3)));
    end else begin
      bl = $urandom_range(2, 1);
      ll_min = $urandom_range(3);
      lh_min = $urandom_range(3);
      set_timing(14'(ll_min), 14'((ll_min == 0 ? 1 : ll_min) + $urandom_range(3)),
                 14'(lh_min), 14'((lh_min == 0 ? 1 : lh_min) + $urandom_range(3)),
                 14'(bl), 14'($urandom_range(bl)), 14'($urandom_range(bl)));
    end
  endtask

  task automatic drain();
    while (pin_samples_q.size() != 0 || in_valid || frame_reports_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic void push_sample(logic level, logic clear);
    sample_t s;
    s.pin = level;
    s.rel = clear;
    pin_samples_q.push_back(s);
    samples_queued++;
  endfunction

  function automatic void push_run(logic level, int unsigned n);
    repeat (n) push_sample(level, $urandom_range(199) == 0);
  endfunction

  function automatic int unsigned pick_len(int unsigned lo, int unsigned hi, bit broken);
    int unsigned low_end;
    int unsigned high_end;
    low_end = (lo < 1) ? 1 : lo;
    high_end = (hi < low_end) ? low_end : hi;
    if (broken && $urandom_range(19) == 0) begin
      if (low_end > 1 && $urandom_range(1) == 1) return $urandom_range(low_end - 1, 1);
      return high_end + $urandom_range(3, 1);
    end
    return $urandom_range(high_end, low_end);
  endfunction

  function automatic void push_byte(logic [ByteW-1:0] data, bit inv, int unsigned low_min,
                                    bit broken);
    int unsigned bl;
    int unsigned hi_len;
    bl = 32'(timing.bit_limit);
    for (int i = 7; i >= 0; i--) begin
      push_run(1'b0, pick_len(low_min, bl, broken));
      if (!inv) begin
        hi_len = data[i] ? pick_len(bl + 1, bl + 4, broken) : pick_len(1, bl, broken);
      end else if (data[i]) begin
        hi_len = pick_len(1, bl, broken);
      end else if ($urandom_range(3) == 0) begin
        hi_len = pick_len(bl, bl, broken);
      end else begin
        hi_len = pick_len(bl, bl + 4, broken);
      end
      push_run(1'b1, hi_len);
    end
  endfunction

  function automatic void push_frame(bit broken, bit release_first);
    logic [ByteW-1:0] addr;
    logic [ByteW-1:0] cmd;
    addr = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom);
    cmd = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom);
    push_sample(1'b1, release_first);
    push_run(1'b1, $urandom_range(3));
    push_run(1'b0, pick_len(32'(timing.lead_low_min), 32'(timing.lead_low_max), broken));
    push_run(1'b1, pick_len(32'(timing.lead_high_min), 32'(timing.lead_high_max), broken));
    push_byte(addr, 1'b0, 0, broken);
    push_byte(addr, 1'b1, 32'(timing.addr_inv_low_min), broken);
    push_byte(cmd, 1'b0, 0, broken);
    push_byte(cmd, 1'b1, 32'(timing.cmd_inv_low_min), broken);
    push_run(1'b0, 1);
  endfunction

  function automatic void push_noise();
    repeat ($urandom_range(20, 1)) push_sample(1'($urandom_range(1)), $urandom_range(19) == 0);
  endfunction

  initial begin
    int unsigned sample_goal;
    int unsigned report_goal;
    init_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 12;
    recv_stall_pct = 54;

    push_sample(1'b1, 1'b1);
    push_run(1'b0, 8);
    push_run(1'b1, 3);
    drain();

    set_timing('0, '0, '0, '0, '0, '0, '0);
    push_sample(1'b1, 1'b1);
    repeat (6) begin
      push_sample(1'b0, 1'b0);
      push_sample(1'b1, 1'b0);
    end
    drain();

    set_timing('1, '1, '1, '1, '1, '1, '1);
    push_sample(1'b1, 1'b1);
    push_run(1'b0, 20);
    push_run(1'b1, 3);
    push_run(1'b0, 2);
    drain();

    set_timing(2, 4, 2, 4, 1, 1, 1);
    push_frame(1'b0, 1'b1);
    push_frame(1'b0, 1'b0);
    push_frame(1'b0, 1'b1);
    drain();

    for (int seg = 0; seg < 3; seg++) begin
      send_idle_pct = (seg == 0) ? 12 : (seg == 1) ? 54 : 0;
      recv_stall_pct = (seg == 0) ? 54 : (seg == 1) ? 12 : 0;
      repeat (2) begin
        pick_timing();
        sample_goal = samples_queued + 60;
        report_goal = reports_predicted + 1;
        while (samples_queued < sample_goal || reports_predicted < report_goal) begin
          if ($urandom_range(9) == 0) push_noise();
          else push_frame($urandom_range(3) == 0, $urandom_range(9) < 6);
          while (pin_samples_q.size() > 64) @(posedge clk);
        end
        drain();
      end
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
rtl/necir_pkg.sv
rtl/necir_core.sv
rtl/necir_out_fifo.sv
rtl/nec_ir_frame_decoder.sv
bench/nec_ir_frame_decoder_tb.sv
